>>> sv/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// shared types, command codes, field layout and the display init rom
// ----------------------------------------------------------------------------
package slcd_pkg;

   localparam int PALETTE_DEPTH_DEF   = 256;
   localparam int PIXELS_PER_WORD_DEF = 4;

   localparam int ROM_ENTRIES = 24;
   localparam int ROM_DATA_MAX = 15;
   localparam int JOB_BYTES = 16;

   // request tdata layout, lowest bit up
   localparam int PAL_INDEX_LSB  = 0;
   localparam int PAL_COLOR_LSB  = 8;
   localparam int X_START_LSB    = 24;
   localparam int Y_START_LSB    = 40;
   localparam int WIN_WIDTH_LSB  = 56;
   localparam int WIN_HEIGHT_LSB = 72;
   localparam int PIXEL_WORD_LSB = 88;
   localparam int REQ_DATA_W     = 120;
   localparam int RSP_DATA_W     = 16;

   localparam logic [7:0] LCD_CASET = 8'h2A;
   localparam logic [7:0] LCD_PASET = 8'h2B;
   localparam logic [7:0] LCD_RAMWR = 8'h2C;
   localparam logic [7:0] COUNT_MASK = 8'h1F;
   localparam int DELAY_BIT = 7;

   // dc pattern of the window header: commands at bytes 0, 5 and 10
   localparam logic [JOB_BYTES-1:0] WINDOW_DC = 16'h03DE;
   localparam logic [4:0] WINDOW_BYTES = 5'd11;

   typedef enum logic [1:0] {
      CMD_PALETTE = 2'd0,
      CMD_INIT    = 2'd1,
      CMD_WINDOW  = 2'd2,
      CMD_PIXEL   = 2'd3
   } cmd_type;

   // one burst of bytes handed from the merge stage to the serializer
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [JOB_BYTES-1:0]      dc;
      logic [4:0]                nbytes;
      logic                      delay;
      logic                      done;
   } job_type;

   function automatic logic [7:0] rom_cmd(input logic [4:0] pos);
      logic [7:0] c;
      case (pos)
         5'd0:  c = 8'hCF;
         5'd1:  c = 8'hED;
         5'd2:  c = 8'hE8;
         5'd3:  c = 8'hCB;
         5'd4:  c = 8'hF7;
         5'd5:  c = 8'hEA;
         5'd6:  c = 8'hC0;
         5'd7:  c = 8'hC1;
         5'd8:  c = 8'hC5;
         5'd9:  c = 8'hC7;
         5'd10: c = 8'h36;
         5'd11: c = 8'h3A;
         5'd12: c = 8'hB1;
         5'd13: c = 8'hF2;
         5'd14: c = 8'h26;
         5'd15: c = 8'hE0;
         5'd16: c = 8'hE1;
         5'd17: c = 8'h2A;
         5'd18: c = 8'h2B;
         5'd19: c = 8'h2C;
         5'd20: c = 8'hB7;
         5'd21: c = 8'hB6;
         5'd22: c = 8'h11;
         5'd23: c = 8'h29;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] rom_count(input logic [4:0] pos);
      logic [7:0] n;
      case (pos)
         5'd0:  n = 8'd3;
         5'd1:  n = 8'd4;
         5'd2:  n = 8'd3;
         5'd3:  n = 8'd5;
         5'd4:  n = 8'd1;
         5'd5:  n = 8'd2;
         5'd6:  n = 8'd1;
         5'd7:  n = 8'd1;
         5'd8:  n = 8'd2;
         5'd9:  n = 8'd1;
         5'd10: n = 8'd1;
         5'd11: n = 8'd1;
         5'd12: n = 8'd2;
         5'd13: n = 8'd1;
         5'd14: n = 8'd1;
         5'd15: n = 8'd15;
         5'd16: n = 8'd15;
         5'd17: n = 8'd4;
         5'd18: n = 8'd4;
         5'd19: n = 8'd0;
         5'd20: n = 8'd1;
         5'd21: n = 8'd4;
         5'd22: n = 8'h80;
         5'd23: n = 8'h80;
         default: n = 8'd0;
      endcase
      return n;
   endfunction

   // element 0 is the first data byte sent
   function automatic logic [ROM_DATA_MAX-1:0][7:0] rom_data(input logic [4:0] pos);
      logic [ROM_DATA_MAX-1:0][7:0] d;
      d = '0;
      case (pos)
         5'd0:  d[2:0] = {8'h30, 8'h83, 8'h00};
         5'd1:  d[3:0] = {8'h81, 8'h12, 8'h03, 8'h64};
         5'd2:  d[2:0] = {8'h79, 8'h01, 8'h85};
         5'd3:  d[4:0] = {8'h02, 8'h34, 8'h00, 8'h2C, 8'h39};
         5'd4:  d[0] = 8'h20;
         5'd6:  d[0] = 8'h26;
         5'd7:  d[0] = 8'h11;
         5'd8:  d[1:0] = {8'h3E, 8'h35};
         5'd9:  d[0] = 8'hBE;
         5'd10: d[0] = 8'h28;
         5'd11: d[0] = 8'h55;
         5'd12: d[1:0] = {8'h1B, 8'h00};
         5'd13: d[0] = 8'h08;
         5'd14: d[0] = 8'h01;
         5'd15: d = {8'h00, 8'h05, 8'h07, 8'h02, 8'h07, 8'h0A, 8'h32, 8'h87,
                     8'h45, 8'h06, 8'h0F, 8'h0A, 8'h18, 8'h1A, 8'h1F};
         5'd16: d = {8'h1F, 8'h3A, 8'h38, 8'h0D, 8'h18, 8'h05, 8'h4D, 8'h78,
                     8'h3A, 8'h09, 8'h10, 8'h05, 8'h27, 8'h25, 8'h00};
         5'd17: d[3:0] = {8'hEF, 8'h00, 8'h00, 8'h00};
         5'd18: d[3:0] = {8'h3F, 8'h01, 8'h00, 8'h00};
         5'd20: d[0] = 8'h07;
         5'd21: d[3:0] = {8'h00, 8'h27, 8'h82, 8'h0A};
         default: d = '0;
      endcase
      return d;
   endfunction

endpackage

>>> sv/slcd_palette_lane.sv
// ----------------------------------------------------------------------------
// slcd_palette_lane
// one palette bank with its own read port, serving one pixel of a word
// ----------------------------------------------------------------------------
module slcd_palette_lane import slcd_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [7:0]  wr_index,
   input  logic [15:0] wr_color,
   input  logic        rd_en,
   input  logic [7:0]  rd_index,
   output logic [15:0] rd_color
);

   localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   // index folding table, worked out at elaboration
   logic [ADDR_W-1:0] fold_tab [256];

   for (genvar i = 0; i < 256; i++) begin : g_fold
      localparam int FOLDED = i % PALETTE_DEPTH;
      assign fold_tab[i] = ADDR_W'(FOLDED);
   end

   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [15:0]       palette_ff [PALETTE_DEPTH];
   logic [15:0]       rd_color_ff;

   assign wr_addr = fold_tab[wr_index];
   assign rd_addr = fold_tab[rd_index];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_ff[wr_addr] <= wr_color;
      end
      if (rd_en) begin
         rd_color_ff <= palette_ff[rd_addr];
      end
   end

   assign rd_color = rd_color_ff;

endmodule

>>> sv/slcd_byte_serializer.sv
// ----------------------------------------------------------------------------
// slcd_byte_serializer
// walks one merged burst a byte per cycle, while the receiver is ready, into the registered result beat
// ----------------------------------------------------------------------------
module slcd_byte_serializer import slcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  job_type               job,
   output logic                  job_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [0:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   job_type    buf_ff;
   logic       busy_ff;
   logic [3:0] idx_ff;
   logic [3:0] idx_in;
   logic       emit;
   logic       is_last;

   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_dc_ff;
   logic       out_delay_ff;
   logic       out_done_ff;
   logic       out_last_ff;

   assign emit      = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign is_last   = (5'({1'b0, idx_ff}) + 5'd1) == buf_ff.nbytes;
   assign job_ready = !busy_ff || (emit && is_last);
   assign idx_in    = idx_ff + 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (job_valid && job_ready) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (emit) begin
         idx_ff <= idx_in;
         if (is_last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         buf_ff <= job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff  <= buf_ff.bytes[idx_ff];
         out_dc_ff    <= buf_ff.dc[idx_ff];
         out_delay_ff <= is_last && buf_ff.delay;
         out_done_ff  <= is_last && buf_ff.done;
         out_last_ff  <= is_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, out_done_ff, out_delay_ff, out_byte_ff};
   assign rsp_tuser  = out_dc_ff;
   assign rsp_tlast  = out_last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (5'({1'b0, idx_ff}) < buf_ff.nbytes))
      else $error("serializer index ran past its burst");

   a_job_size: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (buf_ff.nbytes != 5'd0 && buf_ff.nbytes <= 5'(JOB_BYTES)))
      else $error("burst length out of range");

   a_flags_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (out_delay_ff || out_done_ff)) |-> out_last_ff)
      else $error("delay or init_done flag away from the last byte");

endmodule

>>> sv/spi_lcd_command_and_palette_stream_top.sv
// throughput: one result byte per cycle while rsp_tready is high; a pixel word gives 2*PIXELS_PER_WORD bytes,
// a window header 11, an init step 1 + its data count, a palette write no bytes
// the first byte of an item is registered in stage one, then in the serializer's burst buffer,
// then in its output register
// the next item is taken while the serializer walks the current burst
// reset: synchronous active high, clears init position and all valid flags
// ----------------------------------------------------------------------------
// spi_lcd_command_and_palette_stream_top
// byte stream front end of an spi display: palette load, init rom, window
// header and palette mapped pixel words, one spi byte per result beat
// ----------------------------------------------------------------------------
module spi_lcd_command_and_palette_stream_top import slcd_pkg::*; #(
   parameter int PALETTE_DEPTH   = PALETTE_DEPTH_DEF,
   parameter int PIXELS_PER_WORD = PIXELS_PER_WORD_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pal_index[7:0], pal_color[23:8], x_start[39:24], y_start[55:40],
   // win_width[71:56], win_height[87:72], pixel_word[119:88]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command[1:0]
   input  logic [1:0]            req_tuser,
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_byte[7:0], delay_after[8], init_done[9], zero fill above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // dc_level[0]
   output logic [0:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   // unpacked request fields
   cmd_type     req_cmd;
   logic [7:0]  pal_index;
   logic [15:0] pal_color;
   logic [15:0] x_start;
   logic [15:0] y_start;
   logic [15:0] win_width;
   logic [15:0] win_height;
   logic [31:0] pixel_word;

   assign req_cmd    = cmd_type'(req_tuser);
   assign pal_index  = req_tdata[PAL_INDEX_LSB  +: 8];
   assign pal_color  = req_tdata[PAL_COLOR_LSB  +: 16];
   assign x_start    = req_tdata[X_START_LSB    +: 16];
   assign y_start    = req_tdata[Y_START_LSB    +: 16];
   assign win_width  = req_tdata[WIN_WIDTH_LSB  +: 16];
   assign win_height = req_tdata[WIN_HEIGHT_LSB +: 16];
   assign pixel_word = req_tdata[PIXEL_WORD_LSB +: 32];

   logic       req_fire;
   logic       ser_ready;
   logic       init_live;
   logic [4:0] init_pos_ff;
   logic [4:0] init_pos_in;

   assign req_fire  = req_tvalid && req_tready;
   // init rom not yet exhausted
   assign init_live = init_pos_ff < 5'(ROM_ENTRIES);

   // ---------------------------------------------------------------
   // init rom position
   // ---------------------------------------------------------------
   assign init_pos_in = init_pos_ff + 5'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_pos_ff <= '0;
      end else if (req_fire && req_cmd == CMD_INIT && init_live) begin
         init_pos_ff <= init_pos_in;
      end
   end

   // ---------------------------------------------------------------
   // palette lanes: each pixel of a word has its own bank copy, all
   // banks take every palette write so any lane can read any colour
   // ---------------------------------------------------------------
   logic [15:0] lane_color [PIXELS_PER_WORD];

   for (genvar l = 0; l < PIXELS_PER_WORD; l++) begin : g_lane
      slcd_palette_lane #(
         .PALETTE_DEPTH (PALETTE_DEPTH)
      ) u_lane (
         .clock    (clock),
         .wr_en    (req_fire && req_cmd == CMD_PALETTE),
         .wr_index (pal_index),
         .wr_color (pal_color),
         .rd_en    (req_fire && req_cmd == CMD_PIXEL),
         .rd_index (pixel_word[8*l +: 8]),
         .rd_color (lane_color[l])
      );
   end

   // ---------------------------------------------------------------
   // stage one: decoded item waiting for the serializer
   // ---------------------------------------------------------------
   logic                         s1_valid_ff;
   cmd_type                      s1_kind_ff;
   logic [7:0]                   s1_icmd_ff;
   logic [7:0]                   s1_icount_ff;
   logic [ROM_DATA_MAX-1:0][7:0] s1_irow_ff;
   logic                         s1_ifinal_ff;
   logic [15:0]                  s1_xs_ff;
   logic [15:0]                  s1_xe_ff;
   logic [15:0]                  s1_ys_ff;
   logic [15:0]                  s1_ye_ff;
   logic                         s1_valid_in;
   logic                         s1_move;

   // palette writes and spent init steps make no bytes
   assign s1_valid_in = (req_cmd == CMD_WINDOW) || (req_cmd == CMD_PIXEL) ||
                        (req_cmd == CMD_INIT && init_live);
   assign s1_move     = s1_valid_ff && ser_ready;
   assign req_tready  = !s1_valid_ff || ser_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= s1_valid_in;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff   <= req_cmd;
         s1_icmd_ff   <= rom_cmd(init_pos_ff);
         s1_icount_ff <= rom_count(init_pos_ff);
         s1_irow_ff   <= rom_data(init_pos_ff);
         s1_ifinal_ff <= init_pos_ff == 5'(ROM_ENTRIES - 1);
         s1_xs_ff     <= x_start;
         s1_ys_ff     <= y_start;
         // window ends wrap at 16 bits
         s1_xe_ff     <= x_start + win_width - 16'd1;
         s1_ye_ff     <= y_start + win_height - 16'd1;
      end
   end

   // ---------------------------------------------------------------
   // merge: lay the stage one item and lane colours out as one burst
   // ---------------------------------------------------------------
   job_type    job;
   logic [4:0] icnt;

   always_comb begin
      job  = '0;
      icnt = 5'(s1_icount_ff & COUNT_MASK);
      if (icnt > 5'(ROM_DATA_MAX)) begin
         icnt = 5'(ROM_DATA_MAX);
      end
      case (s1_kind_ff)
         CMD_INIT: begin
            job.bytes[0] = s1_icmd_ff;
            for (int k = 0; k < ROM_DATA_MAX; k++) begin
               job.bytes[k+1] = s1_irow_ff[k];
            end
            job.dc     = ~16'h0001;
            job.nbytes = icnt + 5'd1;
            job.delay  = s1_icount_ff[DELAY_BIT];
            job.done   = s1_ifinal_ff;
         end
         CMD_WINDOW: begin
            job.bytes[0]  = LCD_CASET;
            job.bytes[1]  = s1_xs_ff[15:8];
            job.bytes[2]  = s1_xs_ff[7:0];
            job.bytes[3]  = s1_xe_ff[15:8];
            job.bytes[4]  = s1_xe_ff[7:0];
            job.bytes[5]  = LCD_PASET;
            job.bytes[6]  = s1_ys_ff[15:8];
            job.bytes[7]  = s1_ys_ff[7:0];
            job.bytes[8]  = s1_ye_ff[15:8];
            job.bytes[9]  = s1_ye_ff[7:0];
            job.bytes[10] = LCD_RAMWR;
            job.dc        = WINDOW_DC;
            job.nbytes    = WINDOW_BYTES;
         end
         CMD_PIXEL: begin
            // colour low byte first, then high byte
            for (int l = 0; l < PIXELS_PER_WORD; l++) begin
               job.bytes[2*l]   = lane_color[l][7:0];
               job.bytes[2*l+1] = lane_color[l][15:8];
            end
            job.dc     = '1;
            job.nbytes = 5'(2 * PIXELS_PER_WORD);
         end
         default: begin
            job = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // serializer and result register
   // ---------------------------------------------------------------
   slcd_byte_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (s1_valid_ff),
      .job        (job),
      .job_ready  (ser_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_init_bound: assert property (@(posedge clock) disable iff (reset)
      init_pos_ff <= 5'(ROM_ENTRIES))
      else $error("init position past the rom");

   a_init_advance: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd == CMD_INIT && init_live) |=>
      init_pos_ff == 5'($past(init_pos_ff) + 5'd1))
      else $error("init step did not advance the rom position");

   a_s1_kind: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> s1_kind_ff != CMD_PALETTE)
      else $error("palette write reached the serializer");

endmodule

>>> tb/spi_lcd_command_and_palette_stream_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_lcd_command_and_palette_stream_top_test
// Drives palette loads, init steps, window headers and pixel words into the
// display byte streamer. A behavioral copy of the palette, the init rom walk
// and the window arithmetic works out every spi byte, which is then compared
// beat by beat with the result stream. The run goes through phases of sender
// gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module spi_lcd_command_and_palette_stream_top_test;
   import slcd_pkg::*;

   // number of init rom entries and the cycle limit of the whole run
   localparam int INIT_STEPS = 24;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int PREDICT = -1;

   // init rom: command byte, count byte (bit 7 asks for a pause), data bytes
   // with the first data byte in the lowest bits
   localparam logic [7:0] INIT_CMD [INIT_STEPS] = '{
      8'hCF, 8'hED, 8'hE8, 8'hCB, 8'hF7, 8'hEA, 8'hC0, 8'hC1, 8'hC5, 8'hC7, 8'h36, 8'h3A,
      8'hB1, 8'hF2, 8'h26, 8'hE0, 8'hE1, 8'h2A, 8'h2B, 8'h2C, 8'hB7, 8'hB6, 8'h11, 8'h29};
   localparam logic [7:0] INIT_COUNT [INIT_STEPS] = '{
      8'd3, 8'd4, 8'd3, 8'd5, 8'd1, 8'd2, 8'd1, 8'd1, 8'd2, 8'd1, 8'd1, 8'd1,
      8'd2, 8'd1, 8'd1, 8'd15, 8'd15, 8'd4, 8'd4, 8'd0, 8'd1, 8'd4, 8'h80, 8'h80};
   localparam logic [14:0][7:0] INIT_DATA [INIT_STEPS] = '{
      120'h30_83_00,
      120'h81_12_03_64,
      120'h79_01_85,
      120'h02_34_00_2C_39,
      120'h20,
      120'h00,
      120'h26,
      120'h11,
      120'h3E_35,
      120'hBE,
      120'h28,
      120'h55,
      120'h1B_00,
      120'h08,
      120'h01,
      120'h00_05_07_02_07_0A_32_87_45_06_0F_0A_18_1A_1F,
      120'h1F_3A_38_0D_18_05_4D_78_3A_09_10_05_27_25_00,
      120'hEF_00_00_00,
      120'h3F_01_00_00,
      120'h00,
      120'h07,
      120'h00_27_82_0A,
      120'h00,
      120'h00};

   // one spi byte as it leaves the block
   typedef struct packed {
      logic [7:0] value;
      logic       dc;
      logic       delay;
      logic       done;
      logic       last;
   } spi_beat_type;

   // one request beat; typed rows carry their spi bytes, first byte leftmost
   typedef struct {
      cmd_type         cmd;
      logic [7:0]      idx;
      logic [15:0]     color;
      logic [15:0]     xs;
      logic [15:0]     ys;
      logic [15:0]     ww;
      logic [15:0]     wh;
      logic [31:0]     word;
      int              n_typed;
      logic [0:15][7:0] typed_bytes;
      logic [0:15]     typed_dc;
   } lcd_req_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // pal_index, pal_color, x_start, y_start, win_width, win_height, pixel_word
   logic [REQ_DATA_W-1:0] req_tdata;
   // command
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // out_byte, delay_after, init_done, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // dc_level
   logic [0:0]            rsp_tuser;
   logic                  rsp_tlast;

   // behavioral copy of the block state
   logic [15:0] palette_copy [256];
   bit          palette_filled [256];
   logic [7:0]  filled_idx [$];
   int unsigned init_pos;

   // spi bytes of the item being predicted, and those still owed by the block
   spi_beat_type item_bytes [$];
   spi_beat_type owed_bytes [$];
   spi_beat_type got_beat;
   spi_beat_type want_beat;
   int unsigned  mismatches;

   // handshake pressure, changed per phase by the stimulus process
   int unsigned send_idle_pct;
   int unsigned ready_stall_pct;
   bit          hold_off_go;

   spi_lcd_command_and_palette_stream_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   task automatic emit_byte(input logic [7:0] value, input logic dc);
      spi_beat_type b;
      b.value = value;
      b.dc = dc;
      b.delay = 1'b0;
      b.done = 1'b0;
      b.last = 1'b0;
      item_bytes.push_back(b);
   endtask

   // fills item_bytes with the spi bytes one request beat causes
   task automatic predict_spi_bytes(input lcd_req_type r);
      spi_beat_type b;
      logic [7:0]   cnt;
      logic [15:0]  xe;
      logic [15:0]  ye;
      logic [15:0]  col;
      logic [7:0]   pix;
      item_bytes.delete();
      case (r.cmd)
         CMD_PALETTE: begin
            palette_copy[r.idx] = r.color;
            if (!palette_filled[r.idx]) begin
               palette_filled[r.idx] = 1'b1;
               filled_idx.push_back(r.idx);
            end
         end
         CMD_INIT: begin
            // once the rom is walked through, init steps are dropped
            if (init_pos < INIT_STEPS) begin
               cnt = INIT_COUNT[init_pos] & 8'h1F;
               if (cnt > 8'd15) cnt = 8'd15;
               emit_byte(INIT_CMD[init_pos], 1'b0);
               for (int k = 0; k < cnt; k++) emit_byte(INIT_DATA[init_pos][k], 1'b1);
               b = item_bytes[item_bytes.size() - 1];
               b.delay = INIT_COUNT[init_pos][7];
               b.done = (init_pos == INIT_STEPS - 1);
               item_bytes[item_bytes.size() - 1] = b;
               init_pos++;
            end
         end
         CMD_WINDOW: begin
            xe = r.xs + r.ww - 16'd1;
            ye = r.ys + r.wh - 16'd1;
            emit_byte(8'h2A, 1'b0);
            emit_byte(r.xs[15:8], 1'b1);
            emit_byte(r.xs[7:0], 1'b1);
            emit_byte(xe[15:8], 1'b1);
            emit_byte(xe[7:0], 1'b1);
            emit_byte(8'h2B, 1'b0);
            emit_byte(r.ys[15:8], 1'b1);
            emit_byte(r.ys[7:0], 1'b1);
            emit_byte(ye[15:8], 1'b1);
            emit_byte(ye[7:0], 1'b1);
            emit_byte(8'h2C, 1'b0);
         end
         CMD_PIXEL: begin
            for (int p = 0; p < 4; p++) begin
               pix = r.word[8*p +: 8];
               col = palette_copy[pix];
               emit_byte(col[7:0], 1'b1);
               emit_byte(col[15:8], 1'b1);
            end
         end
      endcase
      if (item_bytes.size() != 0) begin
         b = item_bytes[item_bytes.size() - 1];
         b.last = 1'b1;
         item_bytes[item_bytes.size() - 1] = b;
      end
   endtask

   // called at the edge that takes the request beat
   task automatic log_accepted(input lcd_req_type r);
      spi_beat_type b;
      predict_spi_bytes(r);
      if (r.n_typed != PREDICT) begin
         // typed rows: the state still follows the predictor, the bytes do not
         item_bytes.delete();
         for (int k = 0; k < r.n_typed; k++) begin
            b.value = r.typed_bytes[k];
            b.dc = r.typed_dc[k];
            b.delay = 1'b0;
            b.done = 1'b0;
            b.last = (k == r.n_typed - 1);
            item_bytes.push_back(b);
         end
      end
      foreach (item_bytes[k]) owed_bytes.push_back(item_bytes[k]);
   endtask

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // a: index, start column or pixel word; b: colour or start page;
   // c, d: window width and height
   function automatic lcd_req_type row(input cmd_type cmd, input logic [31:0] a,
                                       input logic [31:0] b, input logic [31:0] c,
                                       input logic [31:0] d, input int n,
                                       input logic [0:15][7:0] bytes,
                                       input logic [0:15] dc);
      lcd_req_type r;
      r.cmd = cmd;
      r.idx = '0;
      r.color = '0;
      r.xs = '0;
      r.ys = '0;
      r.ww = '0;
      r.wh = '0;
      r.word = '0;
      r.n_typed = n;
      r.typed_bytes = bytes;
      r.typed_dc = dc;
      case (cmd)
         CMD_PALETTE: begin
            r.idx = a[7:0];
            r.color = b[15:0];
         end
         CMD_WINDOW: begin
            r.xs = a[15:0];
            r.ys = b[15:0];
            r.ww = c[15:0];
            r.wh = d[15:0];
         end
         CMD_PIXEL: r.word = a;
         default: ;
      endcase
      return r;
   endfunction

   // random beat; fields the command ignores carry noise, pixel indices only
   // point at palette entries that were loaded
   function automatic lcd_req_type random_req();
      lcd_req_type r;
      int unsigned pick;
      r = row(CMD_INIT, 0, 0, 0, 0, PREDICT, '0, '0);
      pick = $urandom_range(99);
      if (pick < 30) r.cmd = CMD_PALETTE;
      else if (pick < 62) r.cmd = CMD_PIXEL;
      else if (pick < 82) r.cmd = CMD_WINDOW;
      else r.cmd = CMD_INIT;
      r.idx = 8'($urandom);
      r.color = 16'($urandom);
      r.xs = 16'($urandom);
      r.ys = 16'($urandom);
      r.ww = 16'($urandom);
      r.wh = 16'($urandom);
      r.word = $urandom;
      if (r.cmd == CMD_PIXEL) begin
         for (int p = 0; p < 4; p++)
            r.word[8*p +: 8] = filled_idx[$urandom_range(filled_idx.size() - 1)];
      end
      return r;
   endfunction

   // offers one request beat and returns at the edge that takes it;
   // tvalid stays high so back to back beats need no second assignment
   task automatic offer_req(input lcd_req_type r);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.cmd;
      req_tdata <= {r.word, r.wh, r.ww, r.ys, r.xs, r.color, r.idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      log_accepted(r);
   endtask

   // ---------------------------------------------------------------------
   // result side: ready pattern and the long hold-off
   // ---------------------------------------------------------------------

   initial begin
      int unsigned hold_left;
      bit          hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_off_go && !hold_used) begin
            // block stays backed up while the sender keeps offering
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= ready_stall_pct);
         end
      end
   end

   // compare each accepted result beat with the oldest owed byte
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_beat.value = rsp_tdata[7:0];
         got_beat.dc = rsp_tuser[0];
         got_beat.delay = rsp_tdata[8];
         got_beat.done = rsp_tdata[9];
         got_beat.last = rsp_tlast;
         if (owed_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 20)
               $display("%0t: unexpected beat byte %h dc %b delay %b done %b last %b",
                        $realtime, got_beat.value, got_beat.dc, got_beat.delay,
                        got_beat.done, got_beat.last);
         end else begin
            want_beat = owed_bytes.pop_front();
            if (got_beat != want_beat || rsp_tdata[RSP_DATA_W-1:10] != '0) begin
               mismatches++;
               if (mismatches <= 20)
                  $display("%0t: byte/dc/delay/done/last expected %h %b %b %b %b",
                           $realtime, want_beat.value, want_beat.dc, want_beat.delay,
                           want_beat.done, want_beat.last,
                           " actual %h %b %b %b %b fill %h",
                           got_beat.value, got_beat.dc,
                           got_beat.delay, got_beat.done, got_beat.last,
                           rsp_tdata[RSP_DATA_W-1:10]);
            end
         end
      end
   end

   // run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   initial begin
      lcd_req_type directed [$];
      lcd_req_type r;
      int unsigned counted;
      bit          dropped;
      // per phase: sender idle, receiver stall, beats, hold-off
      int unsigned phase_idle [5];
      int unsigned phase_stall [5];
      int unsigned phase_beats [5];
      bit          phase_hold [5];

      phase_idle = '{0, 60, 0, 38, 0};
      phase_stall = '{0, 0, 60, 38, 0};
      phase_beats = '{60, 60, 60, 60, 60};
      phase_hold = '{0, 0, 0, 0, 1};

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= CMD_PALETTE;
      init_pos = 0;
      mismatches = 0;
      send_idle_pct = 0;
      ready_stall_pct = 0;
      hold_off_go = 1'b0;
      for (int i = 0; i < 256; i++) begin
         palette_copy[i] = '0;
         palette_filled[i] = 1'b0;
      end

      // directed rows; palette writes give no bytes
      directed.push_back(row(CMD_PALETTE, 32'h00, 32'h0000, 0, 0, 0, '0, '0));
      directed.push_back(row(CMD_PALETTE, 32'hFF, 32'hFFFF, 0, 0, 0, '0, '0));
      directed.push_back(row(CMD_PALETTE, 32'h55, 32'hA5C3, 0, 0, 0, '0, '0));
      directed.push_back(row(CMD_PALETTE, 32'hAA, 32'h5A3C, 0, 0, 0, '0, '0));
      // first init entry after reset
      directed.push_back(row(CMD_INIT, 0, 0, 0, 0, 4, {32'hCF00_8330, 96'h0},
                             16'b0111_0000_0000_0000));
      // zero sizes wrap the ends to ffff
      directed.push_back(row(CMD_WINDOW, 32'h0000, 32'h0000, 32'h0000, 32'h0000, 11,
                             {88'h2A_0000_FFFF_2B_0000_FFFF_2C, 40'h0},
                             16'b0111_1011_1100_0000));
      // all ones everywhere: ends wrap to fffd
      directed.push_back(row(CMD_WINDOW, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 11,
                             {88'h2A_FFFF_FFFD_2B_FFFF_FFFD_2C, 40'h0},
                             16'b0111_1011_1100_0000));
      directed.push_back(row(CMD_WINDOW, 32'hFFFF, 32'h0000, 32'h0001, 32'hFFFF,
                             PREDICT, '0, '0));
      directed.push_back(row(CMD_WINDOW, 32'h0123, 32'h00EF, 32'h0140, 32'h00F0,
                             PREDICT, '0, '0));
      // black and white entries, low index byte first
      directed.push_back(row(CMD_PIXEL, 32'hFF00FF00, 0, 0, 0, 8,
                             {64'h0000_FFFF_0000_FFFF, 64'h0}, 16'hFF00));
      directed.push_back(row(CMD_PIXEL, 32'h00FF00FF, 0, 0, 0, 8,
                             {64'hFFFF_0000_FFFF_0000, 64'h0}, 16'hFF00));
      directed.push_back(row(CMD_PIXEL, 32'hFFFFFFFF, 0, 0, 0, 8,
                             {64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, 16'hFF00));
      directed.push_back(row(CMD_PIXEL, 32'h55AA55AA, 0, 0, 0, PREDICT, '0, '0));
      directed.push_back(row(CMD_INIT, 0, 0, 0, 0, PREDICT, '0, '0));
      directed.push_back(row(CMD_INIT, 0, 0, 0, 0, PREDICT, '0, '0));
      directed.push_back(row(CMD_PALETTE, 32'h80, 32'h8001, 0, 0, 0, '0, '0));
      directed.push_back(row(CMD_PALETTE, 32'h7F, 32'h7FFE, 0, 0, 0, '0, '0));
      directed.push_back(row(CMD_PIXEL, 32'h807F807F, 0, 0, 0, PREDICT, '0, '0));
      // overwrite of a loaded entry
      directed.push_back(row(CMD_PALETTE, 32'h00, 32'h1234, 0, 0, 0, '0, '0));
      directed.push_back(row(CMD_PIXEL, 32'h00000000, 0, 0, 0, PREDICT, '0, '0));
      directed.push_back(row(CMD_WINDOW, 32'h8000, 32'h7FFF, 32'h8000, 32'h8001,
                             PREDICT, '0, '0));
      directed.push_back(row(CMD_INIT, 0, 0, 0, 0, PREDICT, '0, '0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) offer_req(directed[i]);

      // random phases; init steps past the end of the rom are not counted
      for (int ph = 0; ph < 5; ph++) begin
         send_idle_pct = phase_idle[ph];
         ready_stall_pct = phase_stall[ph];
         hold_off_go = phase_hold[ph];
         counted = 0;
         while (counted < phase_beats[ph]) begin
            r = random_req();
            dropped = (r.cmd == CMD_INIT && init_pos >= INIT_STEPS);
            offer_req(r);
            if (!dropped) counted++;
         end
      end
      req_tvalid <= 1'b0;

      // drain, then wait a settle period for stray beats
      while (owed_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
